// File: rtl/prle_pkg.sv
package prle_pkg;

  // largest plane and plane count the block is built for
  localparam logic [12:0] TILE_PIXELS = 13'd4096;
  localparam logic [2:0]  MAX_PLANES  = 3'd4;

  // count code that announces a 16-bit big-endian count
  localparam logic [8:0]  LONG_MARK   = 9'd128;

  // largest run length a record can carry
  localparam logic [12:0] LEN_SAT     = 13'h1FFF;

  // configuration register indexes
  localparam logic CFG_PIXEL_COUNT = 1'b0;
  localparam logic CFG_PLANE_COUNT = 1'b1;

  // stream widths
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 40;
  localparam int CFG_W     = 13;

  // clamped configuration as seen by the parser
  typedef struct packed {
    logic [12:0] pixels;
    logic [2:0]  planes;
  } cfg_eff_t;

  // one run record
  typedef struct packed {
    logic [1:0]  plane;
    logic [11:0] start_pos;
    logic [12:0] run_length;
    logic [7:0]  value;
    logic        overlong;
    logic        tile_done;
  } rec_t;

endpackage

// File: rtl/prle_cfg_regs.sv
module prle_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [prle_pkg::CFG_W-1:0]   cfg_data,
  output prle_pkg::cfg_eff_t           eff
);

  logic [12:0] pixel_count;
  logic [2:0]  plane_count;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count <= prle_pkg::TILE_PIXELS;
      plane_count <= prle_pkg::MAX_PLANES;
    end else if (cfg_we) begin
      case (cfg_index)
        prle_pkg::CFG_PIXEL_COUNT: pixel_count <= cfg_data;
        prle_pkg::CFG_PLANE_COUNT: plane_count <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // clamp out-of-range settings into the legal window
  always_comb begin
    if (pixel_count == 13'd0) begin
      eff.pixels = 13'd1;
    end else if (pixel_count > prle_pkg::TILE_PIXELS) begin
      eff.pixels = prle_pkg::TILE_PIXELS;
    end else begin
      eff.pixels = pixel_count;
    end
    if (plane_count == 3'd0) begin
      eff.planes = 3'd1;
    end else if (plane_count > prle_pkg::MAX_PLANES) begin
      eff.planes = prle_pkg::MAX_PLANES;
    end else begin
      eff.planes = plane_count;
    end
  end

endmodule

// File: rtl/prle_step.sv
module prle_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [7:0]          stream_byte,
  input  prle_pkg::cfg_eff_t  eff,
  output logic                rec_valid,
  output prle_pkg::rec_t      rec
);

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_LONG_HI,
    PH_LONG_LO,
    PH_VALUE,
    PH_LITERAL
  } phase_t;

  phase_t      phase, phase_next;
  logic [12:0] remaining, remaining_next;
  logic [7:0]  long_high, long_high_next;
  logic        is_literal, is_literal_next;
  logic [11:0] position, position_next;
  logic [1:0]  plane_index, plane_index_next;

  logic [8:0]  short_cnt;
  logic [15:0] chk_cnt;
  logic [16:0] chk_sum;
  logic        overlong_hit;
  logic        chk_lit;
  logic [12:0] rec_len;
  logic [13:0] end_sum;
  logic        plane_end;
  logic        last_plane;
  logic        do_check;
  logic        do_rec;

  // count decode, bound check and position update
  always_comb begin
    phase_next       = phase;
    remaining_next   = remaining;
    long_high_next   = long_high;
    is_literal_next  = is_literal;
    position_next    = position;
    plane_index_next = plane_index;
    rec_valid        = 1'b0;
    rec              = '0;
    do_check         = 1'b0;
    do_rec           = 1'b0;

    short_cnt    = stream_byte[7] ? 9'(9'd256 - {1'b0, stream_byte})
                                  : 9'({1'b0, stream_byte} + 9'd1);
    chk_cnt      = (phase == PH_LONG_LO) ? {long_high, stream_byte} : 16'(short_cnt);
    chk_sum      = 17'(position) + 17'(chk_cnt);
    overlong_hit = chk_sum > 17'(eff.pixels);
    chk_lit      = (phase == PH_COUNT) ? stream_byte[7] : is_literal;
    rec_len      = (phase == PH_VALUE) ? remaining : 13'd1;
    end_sum      = 14'(position) + 14'(rec_len);
    plane_end    = end_sum >= 14'(eff.pixels);
    last_plane   = (3'(plane_index) + 3'd1) >= eff.planes;

    // phase step
    case (phase)
      PH_COUNT: begin
        is_literal_next = stream_byte[7];
        if (short_cnt == prle_pkg::LONG_MARK) begin
          phase_next = PH_LONG_HI;
        end else begin
          do_check = 1'b1;
        end
      end
      PH_LONG_HI: begin
        long_high_next = stream_byte;
        phase_next     = PH_LONG_LO;
      end
      PH_LONG_LO: begin
        do_check = 1'b1;
      end
      PH_VALUE: begin
        phase_next     = PH_COUNT;
        remaining_next = '0;
        do_rec         = remaining != 13'd0;
      end
      PH_LITERAL: begin
        if (remaining != 13'd0) begin
          remaining_next = remaining - 13'd1;
        end
        if (remaining <= 13'd1) begin
          phase_next = PH_COUNT;
        end
        do_rec = 1'b1;
      end
      default: begin
        phase_next = PH_COUNT;
      end
    endcase

    // count known: reject runs past the plane end
    if (do_check) begin
      if (overlong_hit) begin
        rec_valid          = 1'b1;
        rec.plane          = plane_index;
        rec.start_pos      = position;
        rec.run_length     = (chk_cnt > 16'(prle_pkg::LEN_SAT)) ? prle_pkg::LEN_SAT
                                                               : chk_cnt[12:0];
        rec.value          = '0;
        rec.overlong       = 1'b1;
        rec.tile_done      = 1'b0;
        phase_next         = PH_COUNT;
        remaining_next     = '0;
        position_next      = '0;
        plane_index_next   = '0;
      end else begin
        remaining_next = chk_cnt[12:0];
        if (chk_lit) begin
          phase_next = (chk_cnt == 16'd0) ? PH_COUNT : PH_LITERAL;
        end else begin
          phase_next = PH_VALUE;
        end
      end
    end

    // run record, with plane and tile end
    if (do_rec) begin
      rec_valid      = 1'b1;
      rec.plane      = plane_index;
      rec.start_pos  = position;
      rec.run_length = rec_len;
      rec.value      = stream_byte;
      rec.overlong   = 1'b0;
      rec.tile_done  = 1'b0;
      position_next  = end_sum[11:0];
      if (plane_end) begin
        position_next  = '0;
        phase_next     = PH_COUNT;
        remaining_next = '0;
        if (last_plane) begin
          plane_index_next = '0;
          rec.tile_done    = 1'b1;
        end else begin
          plane_index_next = plane_index + 2'd1;
        end
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_COUNT;
      remaining   <= '0;
      long_high   <= '0;
      is_literal  <= 1'b0;
      position    <= '0;
      plane_index <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      remaining   <= remaining_next;
      long_high   <= long_high_next;
      is_literal  <= is_literal_next;
      position    <= position_next;
      plane_index <= plane_index_next;
    end
  end

  // a literal phase always has bytes left to take
  a_literal_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_LITERAL |-> remaining != 13'd0)
    else $error("literal phase with no bytes left");

  // an error record restarts the parser at the tile start
  a_error_restart: assert property (@(posedge clk) disable iff (rst)
    advance && rec_valid && rec.overlong |=>
      phase == PH_COUNT && position == 12'd0 && plane_index == 2'd0)
    else $error("parser did not restart after overlong run");

  // a tile end record leaves the parser at plane 0, pixel 0
  a_tile_end: assert property (@(posedge clk) disable iff (rst)
    advance && rec_valid && rec.tile_done |=>
      position == 12'd0 && plane_index == 2'd0 && phase == PH_COUNT)
    else $error("tile end did not return to first plane");

endmodule

// File: rtl/planar_rle_run_decoder.sv
// Planar byte-RLE run decoder.
// Slave stream: one compressed byte per request on s_tdata. Master stream:
// one run record per request; m_tdata carries plane, start position, run
// length and value, m_tuser flags an overlong (error) record and m_tlast
// marks the record that completes the last plane of a tile.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 = pixels per plane, 1 = planes per tile); the user must write only
// while the block is idle, the block does not enforce it. Throughput: one
// byte per cycle while the output is not stalled; a byte is held in the
// input register; parse step and bound check lie between it and the output
// register. Count bytes, long-count bytes and zero-length runs give no
// record, except the error record of an overlong count.
// Reset clears the parser to the count phase at plane 0, pixel 0 and loads
// 4096 pixels and 4 planes. When the receiver stalls the output register
// holds its record; bytes that give no record still pass, and the input
// register takes a new byte whenever its current one moves on.
module planar_rle_run_decoder (
  input  logic                              clk,
  input  logic                              rst,
  // stream_byte[7:0]
  input  logic [prle_pkg::S_TDATA_W-1:0]    s_tdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // plane[1:0], start_pos[13:2], run_length[26:14], value[34:27], zero pad
  output logic [prle_pkg::M_TDATA_W-1:0]    m_tdata,
  // overlong
  output logic                              m_tuser,
  output logic                              m_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [prle_pkg::CFG_W-1:0]        cfg_data
);

  prle_pkg::cfg_eff_t eff;
  prle_pkg::rec_t     rec;
  logic               rec_valid;
  logic               in_valid;
  logic [7:0]         in_byte;
  logic               advance;

  prle_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .eff       (eff)
  );

  prle_step u_step (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .stream_byte (in_byte),
    .eff         (eff),
    .rec_valid   (rec_valid),
    .rec         (rec)
  );

  // byte moves on when its record has room or it makes none
  assign advance  = in_valid && (!m_tvalid || m_tready || !rec_valid);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && rec_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance && rec_valid) begin
      m_tdata <= {5'd0, rec.value, rec.run_length, rec.start_pos, rec.plane};
      m_tuser <= rec.overlong;
      m_tlast <= rec.tile_done;
    end
  end

endmodule
